@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AST_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/awr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awr_pkg
// Shared types and constants of the audio wraparound repair block.
// ----------------------------------------------------------------------------
package awr_pkg;

	localparam int SAMPLE_W        = 24;
	localparam int OUT_W           = 25;
	localparam int CNT_W           = 16;
	localparam int BITS_W          = 5;
	localparam int HIGH_W          = 23;
	localparam int REG_IDX_W       = 2;
	localparam int MAX_SAMPLE_BITS = 24;
	localparam int SUM_W           = OUT_W + 1;
	localparam int IN_TDATA_W      = 24;
	localparam int OUT_TDATA_W     = 48;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SAMPLE_BITS  = 2'd0,
		REG_HIGH_TRIGGER = 2'd1,
		REG_LOW_TRIGGER  = 2'd2,
		REG_CHECK_ONLY   = 2'd3
	} awr_reg_e;

	typedef struct packed {
		logic [BITS_W-1:0]   sample_bits;
		logic [HIGH_W-1:0]   high_trigger;
		logic [SAMPLE_W-1:0] low_trigger;
		logic                check_only;
	} awr_cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_in;
		logic                first_of_run;
	} awr_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] sample_out;
		logic             wrapped;
		logic             wrap_started;
		logic [CNT_W-1:0] wrap_total;
	} awr_result_t;

endpackage
`default_nettype wire

@@ hw/rtl/audio_wraparound_repair_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_wraparound_repair_core
// Detects and repairs sign wraparound in a stream of signed audio samples.
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one raw sample per transaction; tuser marks the first
//   sample of a channel run, which clears the previous sample and open wrap.
// - m_axis returns one result per input: the corrected sample, the running
//   count of wrap starts, and the wrapped / wrap-started flags in tuser.
// - cfg_we/cfg_index/cfg_data write the four control registers; write only
//   while no transaction is in flight.
// - path: a sample accepted into the input register passes the detect/add
//   logic and is presented on m_axis from the result register.
// - throughput: one sample per cycle while m_axis_tready is high; the
//   combinational detect/add path sits between the two registers.
// - reset clears both stages, the run state, the wrap counter and restores
//   the register defaults (16 bits, triggers 16383 / -16384, fix mode).
// - when m_axis_tready is low the result register holds; the input register
//   still fills once, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_wraparound_repair_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [awr_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire logic [awr_pkg::SAMPLE_W-1:0]       cfg_data,
	input  wire logic                               s_axis_tvalid,
	output      logic                               s_axis_tready,
	input  wire logic [awr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [23:0] sample_in
	input  wire logic                               s_axis_tuser,   // [0] first_of_run
	output      logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output      logic [awr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [24:0] sample_out,
	                                                                // [40:25] wrap_total
	output      logic [1:0]                         m_axis_tuser    // [0] wrapped,
	                                                                // [1] wrap_started
);
	import awr_pkg::*;

	awr_cfg_t    cfg;
	awr_item_t   item_s1;
	awr_result_t res;
	awr_result_t res_s2;
	logic        valid_s1;
	logic        valid_s2;
	logic        s2_ready;
	logic        advance;
	logic        in_fire;

	awr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	awr_wrap_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (res)
	);

	assign s2_ready      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && s2_ready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.sample_in    <= s_axis_tdata[SAMPLE_W-1:0];
			item_s1.first_of_run <= s_axis_tuser;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W-CNT_W){1'b0}}, res_s2.wrap_total,
		res_s2.sample_out};
	assign m_axis_tuser  = {res_s2.wrap_started, res_s2.wrapped};

	`AST_IMPLIES(a_start_is_wrapped, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
	`AST_IMPLIES(a_start_counted, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[1], res_s2.wrap_total != '0)
	`AST_IMPLIES(a_full_stall_blocks, clk, arst_n,
		valid_s1 && valid_s2 && !m_axis_tready, !s_axis_tready)
	`AST_NEXT(a_advance_loads_s2, clk, arst_n, advance, valid_s2)

endmodule
`default_nettype wire

@@ hw/rtl/awr_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awr_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module awr_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [awr_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [awr_pkg::SAMPLE_W-1:0]    cfg_data,
	output awr_pkg::awr_cfg_t                    cfg
);
	import awr_pkg::*;

	awr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_bits  <= BITS_W'(16);
			cfg_q.high_trigger <= HIGH_W'(16383);
			cfg_q.low_trigger  <= SAMPLE_W'(-16384);
			cfg_q.check_only   <= 1'b0;
		end else if (cfg_we) begin
			case (awr_reg_e'(cfg_index))
				REG_SAMPLE_BITS:  cfg_q.sample_bits  <= cfg_data[BITS_W-1:0];
				REG_HIGH_TRIGGER: cfg_q.high_trigger <= cfg_data[HIGH_W-1:0];
				REG_LOW_TRIGGER:  cfg_q.low_trigger  <= cfg_data;
				REG_CHECK_ONLY:   cfg_q.check_only   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ hw/rtl/awr_wrap_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awr_wrap_core
// Wrap detection, correction and counting for one sample, with run state.
// ----------------------------------------------------------------------------
module awr_wrap_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire awr_pkg::awr_cfg_t  cfg,
	input  wire awr_pkg::awr_item_t item,
	input  wire logic              advance,
	output awr_pkg::awr_result_t   result
);
	import awr_pkg::*;

	logic [SAMPLE_W-1:0] prev_sample_q;
	logic                inside_q;
	logic                up_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [SAMPLE_W-1:0] prev;
	logic                inw;
	logic                s_neg;
	logic                s_pos;
	logic                wrong;
	logic                up_hit;
	logic                down_hit;
	logic                started;
	logic                wrapped;
	logic                dir;
	logic [CNT_W-1:0]    cnt_next;
	logic [BITS_W-1:0]   bits_lim;
	logic [SUM_W-1:0]    amt;
	logic [SUM_W-1:0]    s_ext;
	logic [SUM_W-1:0]    sum;
	logic [OUT_W-1:0]    sat;

	always_comb begin
		// start of a run drops the previous sample and any open wrap
		prev  = item.first_of_run ? '0 : prev_sample_q;
		inw   = item.first_of_run ? 1'b0 : inside_q;
		s_neg = item.sample_in[SAMPLE_W-1];
		s_pos = !item.sample_in[SAMPLE_W-1] && (item.sample_in != '0);
		wrong = up_q ? s_neg : s_pos;

		up_hit   = ($signed({prev[SAMPLE_W-1], prev}) >
			$signed({2'b00, cfg.high_trigger})) && s_neg;
		down_hit = ($signed(prev) < $signed(cfg.low_trigger)) && s_pos;

		// a wrap end skips the pair check
		started = !inw && (up_hit || down_hit);
		wrapped = inw ? wrong : started;
		dir     = started ? up_hit : up_q;

		cnt_next = (started && (cnt_q != '1)) ? cnt_q + CNT_W'(1) : cnt_q;

		bits_lim = (cfg.sample_bits > BITS_W'(MAX_SAMPLE_BITS)) ?
			BITS_W'(MAX_SAMPLE_BITS) : cfg.sample_bits;
		amt   = (SUM_W'(1) << bits_lim) - SUM_W'(1);
		s_ext = {{(SUM_W-SAMPLE_W){item.sample_in[SAMPLE_W-1]}}, item.sample_in};
		sum   = dir ? s_ext + amt : s_ext - amt;

		// clamp to the output range when the top two bits disagree
		if (sum[SUM_W-1] == sum[SUM_W-2]) begin
			sat = sum[OUT_W-1:0];
		end else if (!sum[SUM_W-1]) begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end else begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end

		result.sample_out   = (wrapped && !cfg.check_only) ? sat :
			{item.sample_in[SAMPLE_W-1], item.sample_in};
		result.wrapped      = wrapped;
		result.wrap_started = started;
		result.wrap_total   = cnt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q <= '0;
			inside_q      <= 1'b0;
			up_q          <= 1'b0;
			cnt_q         <= '0;
		end else if (advance) begin
			prev_sample_q <= item.sample_in;
			inside_q      <= wrapped;
			up_q          <= dir;
			cnt_q         <= cnt_next;
		end
	end

endmodule
`default_nettype wire
